// File: rtl/hsv_value_invert_pixel_assert.svh
// Assertion macros shared by the value-invert RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HSV_VALUE_INVERT_PIXEL_ASSERT_SVH
`define HSV_VALUE_INVERT_PIXEL_ASSERT_SVH

// same-cycle implication
`define HVI_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hvi check failed");

// next-cycle implication
`define HVI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hvi check failed");

`endif

// File: rtl/hvi_pkg.sv
// Types and constants for the HSV value-invert pipeline.
// No dependencies; used by the cells and the top level.
package hvi_pkg;

   localparam logic [7:0] ChanMax = 8'd255;
   localparam int DivCells = 8;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } hvi_chan_type;

   // one word in flight between cells
   typedef struct packed {
      logic         gray;
      hvi_chan_type max_sel;
      logic [7:0]   nmax;
      logic [7:0]   alpha;
      logic         last;
      logic [15:0]  dsh;
      logic [15:0]  rem0;
      logic [15:0]  rem1;
      logic [7:0]   q0;
      logic [7:0]   q1;
   } hvi_stage_type;

endpackage

// File: rtl/hvi_stream_if.sv
// Valid/ready channels for pixel request and response words.
// No dependencies beyond the language.
interface hvi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   logic       last_pixel;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                   input ready);
   modport sink (input valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                 output ready);
endinterface

interface hvi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       last_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, last_out,
                 output ready);
endinterface

// File: rtl/hvi_front.sv
// Front cell: finds value and max channel, forms the scaled numerators.
// Depends on hvi_pkg.
module hvi_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [7:0]            red,
   input  logic [7:0]            green,
   input  logic [7:0]            blue,
   input  logic [7:0]            alpha,
   input  logic                  last,
   input  logic                  alpha_present,
   output logic                  valid_out,
   output hvi_pkg::hvi_stage_type stage_out
);
   import hvi_pkg::*;

   logic          valid_ff;
   hvi_stage_type stage_ff;
   hvi_stage_type stage_in;
   hvi_chan_type  max_sel;
   logic [7:0]    vmax;
   logic [7:0]    nmax;
   logic [7:0]    c0;
   logic [7:0]    c1;

   always_comb begin
      if (red >= green && red >= blue) begin
         max_sel = CH_RED;
         vmax    = red;
         c0      = green;
         c1      = blue;
      end else if (green >= blue) begin
         max_sel = CH_GREEN;
         vmax    = green;
         c0      = red;
         c1      = blue;
      end else begin
         max_sel = CH_BLUE;
         vmax    = blue;
         c0      = red;
         c1      = green;
      end
      nmax = ChanMax - vmax;

      stage_in.gray    = (red == green) && (green == blue);
      stage_in.max_sel = max_sel;
      stage_in.nmax    = nmax;
      stage_in.alpha   = alpha_present ? alpha : 8'd0;
      stage_in.last    = last;
      stage_in.dsh     = {1'b0, vmax, 7'd0};
      // n*c + v/2 stays below 2^16
      stage_in.rem0    = 16'(nmax) * 16'(c0) + 16'(vmax >> 1);
      stage_in.rem1    = 16'(nmax) * 16'(c1) + 16'(vmax >> 1);
      stage_in.q0      = 8'd0;
      stage_in.q1      = 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

// File: rtl/hvi_div_cell.sv
// Divider cell: retires one quotient bit for both scaled channels.
// Depends on hvi_pkg and hsv_value_invert_pixel_assert.svh.
`include "hsv_value_invert_pixel_assert.svh"

module hvi_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_in,
   input  hvi_pkg::hvi_stage_type stage_in,
   output logic                  valid_out,
   output hvi_pkg::hvi_stage_type stage_out
);
   import hvi_pkg::*;

   logic          valid_ff;
   hvi_stage_type stage_ff;
   hvi_stage_type next_in;
   logic          ge0;
   logic          ge1;
   logic          rem0_ok;
   logic          rem1_ok;

   always_comb begin
      ge0          = stage_in.rem0 >= stage_in.dsh;
      ge1          = stage_in.rem1 >= stage_in.dsh;
      next_in      = stage_in;
      next_in.rem0 = ge0 ? stage_in.rem0 - stage_in.dsh : stage_in.rem0;
      next_in.rem1 = ge1 ? stage_in.rem1 - stage_in.dsh : stage_in.rem1;
      next_in.q0   = {stage_in.q0[6:0], ge0};
      next_in.q1   = {stage_in.q1[6:0], ge1};
      next_in.dsh  = stage_in.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= next_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

   // partial remainder must stay below twice the shifted divisor
   assign rem0_ok = {1'b0, stage_in.rem0} < {stage_in.dsh, 1'b0};
   assign rem1_ok = {1'b0, stage_in.rem1} < {stage_in.dsh, 1'b0};

   `HVI_ASSERT_NOW(a_rem0_bound, clock, reset, valid_in && !stage_in.gray, rem0_ok)
   `HVI_ASSERT_NOW(a_rem1_bound, clock, reset, valid_in && !stage_in.gray, rem1_ok)

endmodule

// File: rtl/hsv_value_invert_pixel.sv
// An accepted req word passes the front cell, eight divider cells and the
// response register. Throughput: one word per cycle unless a held rsp
// word waits on ready; each divider cell retires one quotient bit, all
// eight work in parallel. Reset clears all valid flags and alpha_present.
// Depends on hvi_pkg, hvi_stream_if, hvi_front, hvi_div_cell.
`include "hsv_value_invert_pixel_assert.svh"

module hsv_value_invert_pixel (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   hvi_req_if.sink   req_chan,
   hvi_rsp_if.source rsp_chan
);
   import hvi_pkg::*;

   logic            alpha_present_ff;
   logic            advance;
   logic [DivCells:0] valid_sig;
   hvi_stage_type   stage_sig [0:DivCells];
   hvi_stage_type   fin;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_red_ff;
   logic [7:0]      rsp_green_ff;
   logic [7:0]      rsp_blue_ff;
   logic [7:0]      rsp_alpha_ff;
   logic            rsp_last_ff;
   logic [7:0]      rsp_red_in;
   logic [7:0]      rsp_green_in;
   logic [7:0]      rsp_blue_in;
   logic            q0_ok;
   logic            q1_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_present_ff <= 1'b0;
      end else if (csr_wr_en) begin
         alpha_present_ff <= csr_wr_data;
      end
   end

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   hvi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_chan.valid),
      .red           (req_chan.red_in),
      .green         (req_chan.green_in),
      .blue          (req_chan.blue_in),
      .alpha         (req_chan.alpha_in),
      .last          (req_chan.last_pixel),
      .alpha_present (alpha_present_ff),
      .valid_out     (valid_sig[0]),
      .stage_out     (stage_sig[0])
   );

   for (genvar i = 0; i < DivCells; i++) begin : g_cell
      hvi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_sig[i]),
         .stage_in  (stage_sig[i]),
         .valid_out (valid_sig[i+1]),
         .stage_out (stage_sig[i+1])
      );
   end

   assign fin = stage_sig[DivCells];

   always_comb begin
      rsp_red_in   = fin.nmax;
      rsp_green_in = fin.nmax;
      rsp_blue_in  = fin.nmax;
      if (!fin.gray) begin
         unique case (fin.max_sel)
            CH_RED: begin
               rsp_green_in = fin.q0;
               rsp_blue_in  = fin.q1;
            end
            CH_GREEN: begin
               rsp_red_in   = fin.q0;
               rsp_blue_in  = fin.q1;
            end
            CH_BLUE: begin
               rsp_red_in   = fin.q0;
               rsp_green_in = fin.q1;
            end
            default: begin
               rsp_red_in   = fin.nmax;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_sig[DivCells];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
         rsp_alpha_ff <= fin.alpha;
         rsp_last_ff  <= fin.last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = rsp_red_ff;
   assign rsp_chan.green_out = rsp_green_ff;
   assign rsp_chan.blue_out  = rsp_blue_ff;
   assign rsp_chan.alpha_out = rsp_alpha_ff;
   assign rsp_chan.last_out  = rsp_last_ff;

   // scaled channels never exceed the new max
   assign q0_ok = fin.q0 <= fin.nmax;
   assign q1_ok = fin.q1 <= fin.nmax;

   `HVI_ASSERT_NOW(a_q0_range, clock, reset, valid_sig[DivCells] && !fin.gray, q0_ok)
   `HVI_ASSERT_NOW(a_q1_range, clock, reset, valid_sig[DivCells] && !fin.gray, q1_ok)
   `HVI_ASSERT_NEXT(a_rsp_load, clock, reset, valid_sig[DivCells] && advance, rsp_valid_ff)

endmodule
